### hw/rtl/bmpp_pkg.sv
// Shared types and constants for the binomial mod prime power block.
`timescale 1ns / 1ps
package bmpp_pkg;

  localparam int unsigned MaxPk  = 4096;
  localparam int unsigned PW     = 12;
  localparam int unsigned KW     = 4;
  localparam int unsigned MW     = 13;
  localparam int unsigned AW     = 12;
  localparam int unsigned XW     = 64;

  localparam logic [1:0] CfgIdxPrime = 2'd0;
  localparam logic [1:0] CfgIdxExp   = 2'd1;

  typedef struct packed {
    logic          start;
    logic [PW-1:0] a;
    logic [PW-1:0] b;
  } mm_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_F0,
    ST_F1,
    ST_FWD,
    ST_FWAIT,
    ST_I0,
    ST_I1,
    ST_ILAST,
    ST_BWD,
    ST_BWAIT,
    ST_ARGS,
    ST_LOOP,
    ST_DIV,
    ST_RD,
    ST_MS,
    ST_MW,
    ST_CARRY,
    ST_SIGN,
    ST_POW,
    ST_PWAIT,
    ST_FIN
  } state_e;

endpackage

### hw/rtl/bmpp_modmul.sv
// Bit-serial modular multiplier: (a * b) mod m, a below m, one bit of b per cycle.
`timescale 1ns / 1ps
module bmpp_modmul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmpp_pkg::mm_req_t   req_i,
  input  logic [12:0]         mod_i,
  output logic                done_o,
  output logic [11:0]         res_o
);
  import bmpp_pkg::*;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [PW-1:0] a_q, a_d, b_q, b_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [13:0]   t0, t1, t2;

  always_comb begin
    t0 = {1'b0, acc_q, 1'b0} + (b_q[cnt_q] ? {2'b00, a_q} : 14'd0);
    t1 = (t0 >= {1'b0, mod_i}) ? t0 - {1'b0, mod_i} : t0;
    t2 = (t1 >= {1'b0, mod_i}) ? t1 - {1'b0, mod_i} : t1;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 4'(PW - 1);
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = t2[PW-1:0];
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

### hw/rtl/binomial_mod_prime_power.sv
// Top level: C(n,r) mod p^k by Granville's method, tables in two on-chip memories.
// The first query with a legal p and k after reset or a prime or exponent write also builds both tables,
// one entry for each residue below p^k in each table.
// One query at a time; busy_o is high until the done_o strobe, which cannot be stalled.
// Reset (async, active low) clears control state and marks the tables unbuilt.
`timescale 1ns / 1ps
module binomial_mod_prime_power (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] top_count_i,
  input  logic [63:0] choose_count_i,
  output logic        done_o,
  output logic [11:0] residue_o,
  output logic        config_error_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);
  import bmpp_pkg::*;

  state_e        state_q, state_d;
  logic [PW-1:0] prime_q, prime_d;
  logic [KW-1:0] exp_q, exp_d;
  logic          valid_q, valid_d;
  logic [MW-1:0] m_q, m_d;
  logic [3:0]    kcnt_q, kcnt_d;
  logic [MW-1:0] i_q, i_d;
  logic [PW-1:0] imodp_q, imodp_d;
  logic [PW-1:0] prev_q, prev_d;
  logic [XW-1:0] x_q [3];
  logic [XW-1:0] x_d [3];
  logic [PW-1:0] remp_q [3];
  logic [PW-1:0] remp_d [3];
  logic [AW-1:0] remm_q [3];
  logic [AW-1:0] remm_d [3];
  logic [5:0]    bit_q, bit_d;
  logic [1:0]    sel_q, sel_d;
  logic [PW-1:0] ans_q, ans_d;
  logic [4:0]    e0_q, e0_d;
  logic [4:0]    pcnt_q, pcnt_d;
  logic          eq_q, eq_d;
  logic [6:0]    dig_q, dig_d;
  logic          done_q, done_d;
  logic [PW-1:0] res_q, res_d;
  logic          err_q, err_d;

  logic [PW-1:0] uf_mem [MaxPk];
  logic [PW-1:0] inv_mem [MaxPk];
  logic          uf_we, inv_we;
  logic [AW-1:0] uf_waddr, inv_waddr, inv_raddr;
  logic [PW-1:0] uf_wdata, inv_wdata, uf_rdata_q, inv_rdata_q;

  mm_req_t       mm_req;
  logic          mm_done;
  logic [PW-1:0] mm_res;

  logic [24:0]   prod;
  logic          wil;
  logic [PW-1:0] inc_p, dec_p, rd_data;
  logic [12:0]   tp, tm;
  logic          cbit;
  logic [4:0]    e0n;

  bmpp_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .mod_i  (m_q),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  always_ff @(posedge clk_i) begin
    if (uf_we) begin
      uf_mem[uf_waddr] <= uf_wdata;
    end
    uf_rdata_q <= uf_mem[remm_q[0]];
  end

  always_ff @(posedge clk_i) begin
    if (inv_we) begin
      inv_mem[inv_waddr] <= inv_wdata;
    end
    inv_rdata_q <= inv_mem[inv_raddr];
  end

  assign inv_raddr = remm_q[sel_q];
  assign rd_data   = (sel_q == 2'd0) ? uf_rdata_q : inv_rdata_q;
  assign wil       = (prime_q == 12'd2) && (exp_q >= 4'd3);
  assign inc_p     = (imodp_q + 12'd1 == prime_q) ? 12'd0 : imodp_q + 12'd1;
  assign dec_p     = (imodp_q == 12'd0) ? prime_q - 12'd1 : imodp_q - 12'd1;
  assign prod      = {12'd0, m_q} * {13'd0, prime_q};
  assign cbit      = x_q[0][0] ^ x_q[1][0] ^ x_q[2][0];
  assign e0n       = e0_q + {4'd0, cbit};

  always_comb begin
    state_d  = state_q;
    prime_d  = prime_q;
    exp_d    = exp_q;
    valid_d  = valid_q;
    m_d      = m_q;
    kcnt_d   = kcnt_q;
    i_d      = i_q;
    imodp_d  = imodp_q;
    prev_d   = prev_q;
    x_d      = x_q;
    remp_d   = remp_q;
    remm_d   = remm_q;
    bit_d    = bit_q;
    sel_d    = sel_q;
    ans_d    = ans_q;
    e0_d     = e0_q;
    pcnt_d   = pcnt_q;
    eq_d     = eq_q;
    dig_d    = dig_q;
    done_d   = 1'b0;
    res_d    = res_q;
    err_d    = err_q;
    uf_we    = 1'b0;
    uf_waddr = i_q[AW-1:0];
    uf_wdata = prev_q;
    inv_we   = 1'b0;
    inv_waddr = i_q[AW-1:0];
    inv_wdata = prev_q;
    mm_req   = '{start: 1'b0, a: ans_q, b: rd_data};
    tp       = '0;
    tm       = '0;

    if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxPrime) begin
        prime_d = cfg_data_i;
        valid_d = 1'b0;
      end else if (cfg_idx_i == CfgIdxExp) begin
        exp_d   = cfg_data_i[KW-1:0];
        valid_d = 1'b0;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d[0]  = top_count_i;
          x_d[1]  = choose_count_i;
          m_d     = 13'd1;
          kcnt_d  = '0;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (prime_q < 12'd2 || exp_q == 4'd0) begin
          res_d = '0; err_d = 1'b1; state_d = ST_FIN;
        end else if (kcnt_q == exp_q) begin
          state_d = ST_CHECK;
        end else if (prod > 25'(MaxPk)) begin
          res_d = '0; err_d = 1'b1; state_d = ST_FIN;
        end else begin
          m_d    = prod[MW-1:0];
          kcnt_d = kcnt_q + 4'd1;
        end
      end
      ST_CHECK: begin
        state_d = valid_q ? ST_ARGS : ST_F0;
      end
      ST_F0: begin
        uf_we = 1'b1; uf_waddr = '0; uf_wdata = 12'd1;
        state_d = ST_F1;
      end
      ST_F1: begin
        uf_we = 1'b1; uf_waddr = 12'd1; uf_wdata = 12'd1;
        prev_d  = 12'd1;
        i_d     = 13'd2;
        imodp_d = (prime_q == 12'd2) ? 12'd0 : 12'd2;
        state_d = ST_FWD;
      end
      ST_FWD: begin
        if (i_q == m_q) begin
          state_d = ST_I0;
        end else if (imodp_q == 12'd0) begin
          uf_we   = 1'b1;
          i_d     = i_q + 13'd1;
          imodp_d = inc_p;
        end else begin
          mm_req  = '{start: 1'b1, a: prev_q, b: i_q[PW-1:0]};
          state_d = ST_FWAIT;
        end
      end
      ST_FWAIT: begin
        if (mm_done) begin
          uf_we    = 1'b1;
          uf_wdata = mm_res;
          prev_d   = mm_res;
          i_d      = i_q + 13'd1;
          imodp_d  = inc_p;
          state_d  = ST_FWD;
        end
      end
      ST_I0: begin
        inv_we = 1'b1; inv_waddr = '0; inv_wdata = 12'd1;
        state_d = ST_I1;
      end
      ST_I1: begin
        inv_we = 1'b1; inv_waddr = 12'd1; inv_wdata = 12'd1;
        state_d = ST_ILAST;
      end
      ST_ILAST: begin
        inv_we    = 1'b1;
        inv_waddr = m_q[AW-1:0] - 12'd1;
        inv_wdata = wil ? 12'd1 : m_q[PW-1:0] - 12'd1;
        prev_d    = inv_wdata;
        i_d       = m_q - 13'd1;
        imodp_d   = prime_q - 12'd1;
        state_d   = ST_BWD;
      end
      ST_BWD: begin
        inv_waddr = i_q[AW-1:0] - 12'd1;
        if (i_q < 13'd3) begin
          valid_d = 1'b1;
          state_d = ST_ARGS;
        end else if (imodp_q == 12'd0) begin
          inv_we  = 1'b1;
          i_d     = i_q - 13'd1;
          imodp_d = dec_p;
        end else begin
          mm_req  = '{start: 1'b1, a: prev_q, b: i_q[PW-1:0]};
          state_d = ST_BWAIT;
        end
      end
      ST_BWAIT: begin
        inv_waddr = i_q[AW-1:0] - 12'd1;
        if (mm_done) begin
          inv_we    = 1'b1;
          inv_wdata = mm_res;
          prev_d    = mm_res;
          i_d       = i_q - 13'd1;
          imodp_d   = dec_p;
          state_d   = ST_BWD;
        end
      end
      ST_ARGS: begin
        if (x_q[0][XW-1] || x_q[1][XW-1] || x_q[1] > x_q[0]) begin
          res_d = '0; err_d = 1'b0; state_d = ST_FIN;
        end else begin
          x_d[2]  = x_q[0] - x_q[1];
          ans_d   = 12'd1;
          e0_d    = '0;
          eq_d    = 1'b0;
          dig_d   = 7'd1;
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (x_q[0] == '0) begin
          state_d = ST_SIGN;
        end else begin
          for (int j = 0; j < 3; j++) begin
            remp_d[j] = '0;
            remm_d[j] = '0;
          end
          bit_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        for (int j = 0; j < 3; j++) begin
          tp = {remp_q[j], x_q[j][XW-1]};
          tm = {remm_q[j], x_q[j][XW-1]};
          if (tp >= {1'b0, prime_q}) begin
            tp = tp - {1'b0, prime_q};
            x_d[j] = {x_q[j][XW-2:0], 1'b1};
          end else begin
            x_d[j] = {x_q[j][XW-2:0], 1'b0};
          end
          if (tm >= m_q) begin
            tm = tm - m_q;
          end
          remp_d[j] = tp[PW-1:0];
          remm_d[j] = tm[AW-1:0];
        end
        bit_d = bit_q + 6'd1;
        if (bit_q == 6'd63) begin
          sel_d   = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_MS;
      end
      ST_MS: begin
        mm_req.start = 1'b1;
        state_d = ST_MW;
      end
      ST_MW: begin
        if (mm_done) begin
          ans_d = mm_res;
          if (sel_q == 2'd2) begin
            state_d = ST_CARRY;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = ST_RD;
          end
        end
      end
      ST_CARRY: begin
        e0_d  = e0n;
        dig_d = dig_q + 7'd1;
        if (dig_q >= {3'd0, exp_q}) begin
          eq_d = eq_q ^ cbit;
        end
        if (e0n >= {1'b0, exp_q}) begin
          res_d = '0; err_d = 1'b0; state_d = ST_FIN;
        end else begin
          state_d = ST_LOOP;
        end
      end
      ST_SIGN: begin
        if (!wil && eq_q && ans_q != 12'd0) begin
          ans_d = m_q[PW-1:0] - ans_q;
        end
        pcnt_d  = '0;
        state_d = ST_POW;
      end
      ST_POW: begin
        if (pcnt_q == e0_q) begin
          res_d = ans_q; err_d = 1'b0; state_d = ST_FIN;
        end else begin
          mm_req  = '{start: 1'b1, a: ans_q, b: prime_q};
          state_d = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (mm_done) begin
          ans_d   = mm_res;
          pcnt_d  = pcnt_q + 5'd1;
          state_d = ST_POW;
        end
      end
      ST_FIN: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prime_q <= 12'd2;
      exp_q   <= 4'd1;
      valid_q <= 1'b0;
      done_q  <= 1'b0;
      kcnt_q  <= '0;
      bit_q   <= '0;
      sel_q   <= '0;
      pcnt_q  <= '0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      prime_q <= prime_d;
      exp_q   <= exp_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      kcnt_q  <= kcnt_d;
      bit_q   <= bit_d;
      sel_q   <= sel_d;
      pcnt_q  <= pcnt_d;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    i_q     <= i_d;
    imodp_q <= imodp_d;
    prev_q  <= prev_d;
    x_q     <= x_d;
    remp_q  <= remp_d;
    remm_q  <= remm_d;
    ans_q   <= ans_d;
    e0_q    <= e0_d;
    eq_q    <= eq_d;
    res_q   <= res_d;
    err_q   <= err_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign residue_o      = res_q;
  assign config_error_o = err_q;

endmodule

### dv/testbench.sv
// Self-checking testbench for binomial_mod_prime_power: directed table then random queries.
`timescale 1ns / 1ps
module testbench;
  import bmpp_pkg::*;

  typedef struct {
    logic [11:0] res;
    logic        err;
  } binom_out_t;

  typedef struct {
    logic [11:0] p;
    logic [3:0]  k;
    longint      n;
    longint      r;
    bit          typed;
    logic [11:0] res;
    logic        err;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [63:0] top_count_i = '0;
  logic [63:0] choose_count_i = '0;
  logic        done_o;
  logic [11:0] residue_o;
  logic        config_error_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgIdxPrime;
  logic [11:0] cfg_data_i = '0;

  binomial_mod_prime_power i_dut (.*);

  always #6 clk_i = ~clk_i;

  logic [11:0] cur_p = 12'd2;
  logic [3:0]  cur_k = 4'd1;
  logic [11:0] fact_tbl [MaxPk];
  logic [11:0] inv_tbl [MaxPk];
  bit          tbl_ok = 0;
  binom_out_t  pending_q[$];
  dir_row_t    dir_rows[$];
  int          fails = 0;
  int          idle_cnt = 0;

  function automatic int unsigned modulus_now();
    longint unsigned m;
    m = 1;
    if (cur_p < 2 || cur_k < 1) return 0;
    for (int j = 0; j < cur_k; j++) begin
      m = m * cur_p;
      if (m > MaxPk) return 0;
    end
    return int'(m);
  endfunction

  function automatic binom_out_t binom_mod(longint unsigned n, longint unsigned r);
    binom_out_t o;
    int unsigned m, e0, eq;
    longint unsigned p, ans, nr, c;
    bit wil;
    m = modulus_now();
    p = cur_p;
    e0 = 0;
    eq = 0;
    wil = (cur_p == 2 && cur_k >= 3);
    o.res = '0;
    o.err = 1'b0;
    if (m == 0) begin
      o.err = 1'b1;
      return o;
    end
    if (!tbl_ok) begin
      fact_tbl[0] = 12'(1 % m);
      fact_tbl[1] = 12'(1 % m);
      for (int unsigned i = 2; i < m; i++)
        fact_tbl[i] = (i % p == 0) ? fact_tbl[i-1] : 12'((longint'(i) * fact_tbl[i-1]) % m);
      inv_tbl[0] = 12'(1 % m);
      inv_tbl[1] = 12'(1 % m);
      inv_tbl[m-1] = wil ? 12'd1 : 12'(m - 1);
      for (int unsigned i = m - 1; i > 2; i--)
        inv_tbl[i-1] = (i % p == 0) ? inv_tbl[i] : 12'((longint'(inv_tbl[i]) * i) % m);
      tbl_ok = 1;
    end
    if (n[63] || r[63] || r > n) return o;
    nr = n - r;
    ans = 1 % m;
    for (int unsigned i = 1; n != 0; i++) begin
      ans = (ans * fact_tbl[n % m]) % m;
      ans = (ans * inv_tbl[r % m]) % m;
      ans = (ans * inv_tbl[nr % m]) % m;
      n = n / p;
      r = r / p;
      nr = nr / p;
      c = n - r - nr;
      e0 += c[31:0];
      if (e0 >= cur_k) return o;
      if (i >= cur_k) eq += c[31:0];
    end
    if (!wil && eq[0]) ans = (m - ans) % m;
    for (int unsigned j = 0; j < e0; j++) ans = (ans * p) % m;
    o.res = ans[11:0];
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      pending_q.push_back(binom_mod(top_count_i, choose_count_i));
  end

  always @(posedge clk_i) begin
    binom_out_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer residue=%0d", residue_o);
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (residue_o !== e.res) begin
          $error("residue expected %0d actual %0d", e.res, residue_o);
          fails++;
        end
        if (config_error_o !== e.err) begin
          $error("config_error expected %0d actual %0d", e.err, config_error_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt > 600000) begin
      $display("binomial_mod_prime_power verification failed");
      $finish;
    end
  end

  task automatic add_row(int p, int k, longint n, longint r, bit typed, int res, int err);
    dir_row_t d;
    d.p = 12'(p);
    d.k = 4'(k);
    d.n = n;
    d.r = r;
    d.typed = typed;
    d.res = 12'(res);
    d.err = 1'(err);
    dir_rows.push_back(d);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_q.size() != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(logic [11:0] p, logic [11:0] kdata);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgIdxPrime;
    cfg_data_i <= p;
    @(negedge clk_i);
    cfg_idx_i <= CfgIdxExp;
    cfg_data_i <= kdata;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_p = p;
    cur_k = kdata[3:0];
    tbl_ok = 0;
    @(negedge clk_i);
  endtask

  task automatic xfer(longint n, longint r, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    top_count_i <= n;
    choose_count_i <= r;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  function automatic int rand_gap();
    int v;
    v = $urandom_range(0, 99);
    if (v < 50) return 0;
    if (v < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  task automatic rand_pair(int m, output longint n, output longint r);
    longint unsigned un, ur;
    int mode;
    if (m < 2) m = 2;
    mode = $urandom_range(0, 9);
    un = {$urandom, $urandom};
    ur = {$urandom, $urandom};
    case (mode)
      0, 1, 2, 3: begin
        un = $urandom_range(0, 3 * m);
        ur = ur % (un + 1);
      end
      4, 5, 6: begin
        un[63] = 1'b0;
        ur = ur % (un + 1);
      end
      7: begin
        un[63] = 1'b0;
        ur = un - (ur % 3) * $urandom_range(0, 1);
        if (ur > un) ur = un;
      end
      8: begin
        un = $urandom_range(0, 2 * m);
        ur = un + 1 + $urandom_range(0, 50);
      end
      default: ;
    endcase
    n = un;
    r = ur;
  endtask

  initial begin
    int primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61};
    longint n, r, mx, mn;
    int p, k, kmax, mm;
    binom_out_t e;
    mx = 64'h7fff_ffff_ffff_ffff;
    mn = 64'h8000_0000_0000_0000;
    add_row(2, 1, 0, 0, 1, 1, 0);
    add_row(2, 1, -1, 0, 1, 0, 0);
    add_row(2, 1, 5, -1, 1, 0, 0);
    add_row(2, 1, 3, 7, 1, 0, 0);
    add_row(2, 1, mx, 0, 1, 1, 0);
    add_row(2, 1, mn, mn, 1, 0, 0);
    add_row(2, 1, mx, mx, 0, 0, 0);
    add_row(2, 1, 10, 3, 0, 0, 0);
    add_row(3, 4, 20, 7, 0, 0, 0);
    add_row(3, 4, 80, 40, 0, 0, 0);
    add_row(3, 4, mx, 12345, 0, 0, 0);
    add_row(2, 3, 7, 3, 0, 0, 0);
    add_row(2, 3, 100, 37, 0, 0, 0);
    add_row(2, 12, 4095, 1000, 0, 0, 0);
    add_row(2, 12, mx, 123456789, 0, 0, 0);
    add_row(4093, 1, 4092, 1, 0, 0, 0);
    add_row(4093, 1, 8000000, 4093, 0, 0, 0);
    add_row(4, 3, 50, 17, 0, 0, 0);
    add_row(6, 2, 35, 12, 0, 0, 0);
    add_row(7, 4, 49, 7, 0, 0, 0);
    add_row(4093, 2, 1, 0, 1, 0, 1);
    add_row(2, 15, 5, 2, 1, 0, 1);
    add_row(1, 3, 3, 1, 1, 0, 1);
    add_row(5, 0, -3, 1, 1, 0, 1);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].p != cur_p || dir_rows[i].k != cur_k)
        set_config(dir_rows[i].p, {8'h00, dir_rows[i].k});
      if (dir_rows[i].typed) begin
        e = binom_mod(dir_rows[i].n, dir_rows[i].r);
        if (e.res !== dir_rows[i].res) begin
          $error("table row %0d residue expected %0d actual %0d", i, dir_rows[i].res, e.res);
          fails++;
        end
        if (e.err !== dir_rows[i].err) begin
          $error("table row %0d config_error expected %0d actual %0d", i, dir_rows[i].err,
                 e.err);
          fails++;
        end
        tbl_ok = 0;
      end
      xfer(dir_rows[i].n, dir_rows[i].r, rand_gap());
    end

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        p = 2;
        k = 12;
      end else if (ph == 5) begin
        p = $urandom_range(65, 4095);
        k = $urandom_range(2, 15);
      end else begin
        p = primes[$urandom_range(0, primes.size() - 1)];
        kmax = 1;
        mm = p;
        while (mm * p <= 1024) begin
          mm = mm * p;
          kmax++;
        end
        k = $urandom_range(1, kmax);
      end
      set_config(12'(p), {4'($urandom), 4'($urandom), 4'(k)});
      mm = modulus_now();
      for (int i = 0; i < 17; i++) begin
        rand_pair(mm, n, r);
        xfer(n, r, (i < 5) ? 0 : rand_gap());
      end
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("binomial_mod_prime_power verification clean");
    end else begin
      $display("binomial_mod_prime_power verification failed");
    end
    $finish;
  end

endmodule
